### hw/rtl/ftbb_pkg.sv
// Shared types and constants for the feedback token bounding box unit.
package ftbb_pkg;

  localparam int WORD_W  = 21;
  localparam int CODE_W  = 16;
  localparam int COUNT_W = 15;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHOSEN_NAME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARKER_CODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLYGON_CODE = 2'd2;

  localparam logic [CODE_W-1:0] CHOSEN_NAME_RST  = 16'd0;
  localparam logic [CODE_W-1:0] MARKER_CODE_RST  = 16'd1792;
  localparam logic [CODE_W-1:0] POLYGON_CODE_RST = 16'd1795;

  localparam logic signed [WORD_W-1:0] SENTINEL_POS = 21'sd999999;
  localparam logic signed [WORD_W-1:0] SENTINEL_NEG = -21'sd999999;
  localparam logic [COUNT_W-1:0]       COUNT_MAX    = 15'd32767;

  // One classified word as it travels from the front to the back
  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     last;
    logic                     is_marker;
    logic                     is_name;
    logic                     is_polygon;
    logic [COUNT_W-1:0]       count;
  } cls_item_t;

endpackage

### hw/rtl/ftbb_front.sv
// Front end: configuration registers and token classification of each word.
module ftbb_front
  import ftbb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CODE_W-1:0]        cfg_data,
  input  logic signed [WORD_W-1:0] word,
  input  logic                     last_word,
  output cls_item_t                item
);

  logic [CODE_W-1:0] chosen_name;
  logic [CODE_W-1:0] marker_code;
  logic [CODE_W-1:0] polygon_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      chosen_name  <= CHOSEN_NAME_RST;
      marker_code  <= MARKER_CODE_RST;
      polygon_code <= POLYGON_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHOSEN_NAME:  chosen_name  <= cfg_data;
        REG_MARKER_CODE:  marker_code  <= cfg_data;
        REG_POLYGON_CODE: polygon_code <= cfg_data;
        default: ;
      endcase
    end
  end

  logic fits_code;

  always_comb begin
    // negative words or words above 16 bits never match a code
    fits_code       = (word[WORD_W-1:CODE_W] == '0);
    item.word       = word;
    item.last       = last_word;
    item.is_marker  = fits_code && (word[CODE_W-1:0] == marker_code);
    item.is_name    = fits_code && (word[CODE_W-1:0] == chosen_name);
    item.is_polygon = fits_code && (word[CODE_W-1:0] == polygon_code);
    if (word[WORD_W-1] || (word == '0)) begin
      item.count = '0;
    end else if (word[WORD_W-2:COUNT_W] != '0) begin
      item.count = COUNT_MAX;
    end else begin
      item.count = word[COUNT_W-1:0];
    end
  end

endmodule

### hw/rtl/ftbb_queue.sv
// Short queue of classified words between front and back.
module ftbb_queue
  import ftbb_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cls_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output cls_item_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cls_item_t          slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/ftbb_back.sv
// Back end: object/polygon parser, running min/max and result register.
module ftbb_back
  import ftbb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     head_valid,
  input  cls_item_t                head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] rect_left,
  output logic signed [WORD_W-1:0] rect_right,
  output logic signed [WORD_W-1:0] rect_top,
  output logic signed [WORD_W-1:0] rect_bottom,
  output logic                     matched
);

  typedef enum logic [2:0] {
    PH_SEEK, PH_NAME, PH_BODY, PH_COUNT, PH_X, PH_Y, PH_DONE
  } phase_t;

  phase_t                   phase, phase_next;
  logic [COUNT_W-1:0]       vertices_left, vertices_left_next;
  logic signed [WORD_W-1:0] min_x, min_x_next, max_x, max_x_next;
  logic signed [WORD_W-1:0] min_y, min_y_next, max_y, max_y_next;
  logic                     found, found_next;
  logic                     slot_free;

  assign slot_free = !out_valid || out_ready;
  // only the last word needs the result register
  assign pop = head_valid && (!head.last || slot_free);

  always_comb begin
    phase_next         = phase;
    vertices_left_next = vertices_left;
    min_x_next         = min_x;
    max_x_next         = max_x;
    min_y_next         = min_y;
    max_y_next         = max_y;
    found_next         = found;
    unique case (phase)
      PH_SEEK: if (head.is_marker) phase_next = PH_NAME;
      PH_NAME: begin
        if (head.is_name) begin
          found_next = 1'b1;
          phase_next = PH_BODY;
        end else if (!head.is_marker) begin
          phase_next = PH_SEEK;
        end
      end
      PH_BODY: begin
        if (head.is_marker) phase_next = PH_DONE;
        else if (head.is_polygon) phase_next = PH_COUNT;
      end
      PH_COUNT: begin
        vertices_left_next = head.count;
        phase_next = (head.count == '0) ? PH_BODY : PH_X;
      end
      PH_X: begin
        if (head.word > max_x) max_x_next = head.word;
        if (head.word < min_x) min_x_next = head.word;
        phase_next = PH_Y;
      end
      PH_Y: begin
        if (head.word > max_y) max_y_next = head.word;
        if (head.word < min_y) min_y_next = head.word;
        if (vertices_left != '0) vertices_left_next = vertices_left - 1'b1;
        phase_next = (vertices_left_next == '0) ? PH_BODY : PH_X;
      end
      PH_DONE: ;
      default: phase_next = PH_SEEK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEEK;
      vertices_left <= '0;
      min_x         <= SENTINEL_POS;
      max_x         <= SENTINEL_NEG;
      min_y         <= SENTINEL_POS;
      max_y         <= SENTINEL_NEG;
      found         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (pop) begin
        if (head.last) begin
          rect_left   <= min_x_next;
          rect_right  <= max_x_next;
          rect_top    <= min_y_next;
          rect_bottom <= max_y_next;
          matched     <= found_next;
          out_valid   <= 1'b1;
          // buffer end: back to a clean scan
          phase         <= PH_SEEK;
          vertices_left <= '0;
          min_x         <= SENTINEL_POS;
          max_x         <= SENTINEL_NEG;
          min_y         <= SENTINEL_POS;
          max_y         <= SENTINEL_NEG;
          found         <= 1'b0;
        end else begin
          phase         <= phase_next;
          vertices_left <= vertices_left_next;
          min_x         <= min_x_next;
          max_x         <= max_x_next;
          min_y         <= min_y_next;
          max_y         <= max_y_next;
          found         <= found_next;
        end
      end
    end
  end

endmodule

### hw/rtl/feedback_token_bounding_box_unit.sv
// At best the rectangle becomes valid on m_axis after the queue and then the result register.
// Throughput: one word per cycle unless the queue is full; the back end consumes one
//   queued word per cycle and stalls only when a last word meets an untaken result in the
//   output register.
// The QUEUE_DEPTH-entry queue lets input keep flowing while the output side stalls.
// Reset (rst, synchronous) restores the registers to their defaults and starts a new scan.
module feedback_token_bounding_box_unit
  import ftbb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // word[20:0], zero pad
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // rect_left, rect_right, rect_top, rect_bottom (21 bits each), matched, zero pad
  output logic [87:0]          m_axis_tdata
);

  cls_item_t                fr_item;
  cls_item_t                q_head;
  logic                     q_full;
  logic                     q_not_empty;
  logic                     q_pop;
  logic                     push;
  logic signed [WORD_W-1:0] rect_left, rect_right, rect_top, rect_bottom;
  logic                     matched;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  ftbb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .word      (s_axis_tdata[WORD_W-1:0]),
    .last_word (s_axis_tlast),
    .item      (fr_item)
  );

  ftbb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (fr_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ftbb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_not_empty),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .rect_left   (rect_left),
    .rect_right  (rect_right),
    .rect_top    (rect_top),
    .rect_bottom (rect_bottom),
    .matched     (matched)
  );

  assign m_axis_tdata = {3'b000, matched, rect_bottom, rect_top, rect_right, rect_left};

`ifndef SYNTHESIS
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty) else $error("queue popped while empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push) else $error("word transfer into a full queue");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("result valid right after reset");

  a_unmatched_empty_rect: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !matched) |->
      (rect_left == SENTINEL_POS && rect_right == SENTINEL_NEG &&
       rect_top == SENTINEL_POS && rect_bottom == SENTINEL_NEG))
    else $error("coordinates gathered without a matched object");
`endif

endmodule

### dv/feedback_token_bounding_box_checker.sv
// Checker for the feedback token bounding box unit: scan predictor and rectangle scoreboard.
module feedback_token_bounding_box_checker
  import ftbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // word[20:0], zero pad
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // rect_left, rect_right, rect_top, rect_bottom (21 bits each), matched, zero pad
  input  logic [87:0]          m_axis_tdata,
  output int                   fail_count,
  output int                   pending,
  output int                   rects_checked
);

  typedef enum logic [2:0] {
    SCAN_SEEK, SCAN_NAME, SCAN_BODY, SCAN_COUNT, SCAN_X, SCAN_Y, SCAN_DONE
  } scan_phase_t;

  // Declared high field first so that left_x lands in the lowest bits, as on m_axis_tdata
  typedef struct packed {
    logic                     matched;
    logic signed [WORD_W-1:0] bottom_y;
    logic signed [WORD_W-1:0] top_y;
    logic signed [WORD_W-1:0] right_x;
    logic signed [WORD_W-1:0] left_x;
  } bbox_t;

  logic [CODE_W-1:0]        name_code;
  logic [CODE_W-1:0]        marker;
  logic [CODE_W-1:0]        polygon;
  scan_phase_t              phase;
  logic [COUNT_W-1:0]       vertices_left;
  logic signed [WORD_W-1:0] min_x, max_x, min_y, max_y;
  logic                     found;
  bbox_t                    expected_boxes[$];

  // A negative word or one above 16 bits never equals a code
  function automatic logic is_code(input logic signed [WORD_W-1:0] w,
                                   input logic [CODE_W-1:0] code);
    return (w[WORD_W-1:CODE_W] == '0) && (w[CODE_W-1:0] == code);
  endfunction

  task automatic clear_scan();
    phase         = SCAN_SEEK;
    vertices_left = '0;
    min_x         = SENTINEL_POS;
    max_x         = SENTINEL_NEG;
    min_y         = SENTINEL_POS;
    max_y         = SENTINEL_NEG;
    found         = 1'b0;
  endtask

  task automatic scan_word(input logic signed [WORD_W-1:0] w, input logic lst);
    bbox_t b;
    case (phase)
      SCAN_SEEK: if (is_code(w, marker)) phase = SCAN_NAME;
      SCAN_NAME: begin
        if (is_code(w, name_code)) begin
          found = 1'b1;
          phase = SCAN_BODY;
        end else if (!is_code(w, marker)) begin
          phase = SCAN_SEEK;
        end
      end
      SCAN_BODY: begin
        if (is_code(w, marker)) phase = SCAN_DONE;
        else if (is_code(w, polygon)) phase = SCAN_COUNT;
      end
      SCAN_COUNT: begin
        if (w <= 0) begin
          vertices_left = '0;
          phase = SCAN_BODY;
        end else begin
          // saturate at the counter width
          vertices_left = (w[WORD_W-1:COUNT_W] != '0) ? COUNT_MAX : w[COUNT_W-1:0];
          phase = SCAN_X;
        end
      end
      SCAN_X: begin
        if (w > max_x) max_x = w;
        if (w < min_x) min_x = w;
        phase = SCAN_Y;
      end
      SCAN_Y: begin
        if (w > max_y) max_y = w;
        if (w < min_y) min_y = w;
        if (vertices_left != '0) vertices_left = vertices_left - 1'b1;
        phase = (vertices_left == '0) ? SCAN_BODY : SCAN_X;
      end
      default: ;
    endcase
    if (lst) begin
      b.left_x   = min_x;
      b.right_x  = max_x;
      b.top_y    = min_y;
      b.bottom_y = max_y;
      b.matched  = found;
      expected_boxes.push_back(b);
      clear_scan();
    end
  endtask

  task automatic cmp_field(input string fname, input logic signed [WORD_W-1:0] want,
                           input logic signed [WORD_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  task automatic check_box(input bbox_t want, input logic [87:0] d);
    bbox_t got;
    got = d[84:0];
    cmp_field("rect_left", want.left_x, got.left_x);
    cmp_field("rect_right", want.right_x, got.right_x);
    cmp_field("rect_top", want.top_y, got.top_y);
    cmp_field("rect_bottom", want.bottom_y, got.bottom_y);
    cmp_field("matched", {20'd0, want.matched}, {20'd0, got.matched});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      name_code     = CHOSEN_NAME_RST;
      marker        = MARKER_CODE_RST;
      polygon       = POLYGON_CODE_RST;
      fail_count    = 0;
      rects_checked = 0;
      expected_boxes.delete();
      clear_scan();
    end else begin
      // output first: a rectangle can never belong to a word taken at the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_boxes.size() == 0) begin
          fail_count++;
          $display("%0t: rectangle with none expected, expected nothing, actual %h",
                   $time, m_axis_tdata[84:0]);
        end else begin
          check_box(expected_boxes.pop_front(), m_axis_tdata);
          rects_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        scan_word(s_axis_tdata[WORD_W-1:0], s_axis_tlast);
      if (cfg_we) begin
        case (cfg_index)
          REG_CHOSEN_NAME:  name_code = cfg_data;
          REG_MARKER_CODE:  marker    = cfg_data;
          REG_POLYGON_CODE: polygon   = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_boxes.size();
  end

endmodule

### dv/tb_feedback_token_bounding_box_unit.sv
// Testbench top for the feedback token bounding box unit: stimulus, flow control and verdict.
module tb_feedback_token_bounding_box_unit;
  import ftbb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 80;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0]    cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [23:0]          s_axis_tdata = '0;  // word[20:0], zero pad
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // rect_left, rect_right, rect_top, rect_bottom (21 bits each), matched, zero pad
  logic [87:0]          m_axis_tdata;

  int fail_count, pending, rects_checked;
  int tx_idle_pct = 29;
  int rx_idle_pct = 29;
  logic rx_hold_req = 1'b0;
  int words_sent = 0;
  int buffers_sent = 0;
  int settings_used = 1;
  int cycle_count = 0;

  // current register values, used to shape the generated buffers
  logic [CODE_W-1:0] name_q    = CHOSEN_NAME_RST;
  logic [CODE_W-1:0] marker_q  = MARKER_CODE_RST;
  logic [CODE_W-1:0] polygon_q = POLYGON_CODE_RST;

  logic signed [WORD_W-1:0] frame_words[$];

  feedback_token_bounding_box_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  feedback_token_bounding_box_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending(pending), .rects_checked(rects_checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic logic signed [WORD_W-1:0] noise_word();
    case ($urandom_range(0, 5))
      0: return WORD_W'($urandom);
      1: return WORD_W'($urandom_range(0, 15));
      2: return WORD_W'(marker_q + $urandom_range(0, 2) - 1);
      3: return {5'd1, polygon_q};  // aliases a code above 16 bits
      4: return -$signed({5'd0, marker_q});
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic signed [WORD_W-1:0] coord_word();
    if ($urandom_range(0, 7) == 0) return WORD_W'($urandom);
    return WORD_W'($urandom_range(0, 4095) - 2048);
  endfunction

  // Mostly well-formed buffers with random content; some noise and cut-short ones
  task automatic build_frame();
    int n_poly, n_vert, p, v;
    frame_words.delete();
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 8)) frame_words.push_back(noise_word());
    end else begin
      repeat ($urandom_range(0, 2)) frame_words.push_back(noise_word());
      if ($urandom_range(0, 3) == 0) begin
        frame_words.push_back(WORD_W'(marker_q));
        frame_words.push_back(WORD_W'(name_q + 16'd1));
      end
      if ($urandom_range(0, 9) != 0) begin
        frame_words.push_back(WORD_W'(marker_q));
        frame_words.push_back(WORD_W'(name_q));
        n_poly = $urandom_range(0, 3);
        for (p = 0; p < n_poly; p++) begin
          frame_words.push_back(WORD_W'(polygon_q));
          case ($urandom_range(0, 19))
            0: n_vert = -int'($urandom_range(0, 5));
            1: n_vert = $urandom_range(32768, 1048575);
            default: n_vert = $urandom_range(1, 4);
          endcase
          frame_words.push_back(WORD_W'(n_vert));
          // oversized count or an occasional early end: buffer stops mid polygon
          if (n_vert > 4 || $urandom_range(0, 14) == 0) begin
            repeat ($urandom_range(1, 5)) frame_words.push_back(coord_word());
            return;
          end
          for (v = 0; v < 2 * n_vert; v++) frame_words.push_back(coord_word());
          if ($urandom_range(0, 1) == 0) frame_words.push_back(noise_word());
        end
        if ($urandom_range(0, 4) != 0) frame_words.push_back(WORD_W'(marker_q));
      end
      repeat ($urandom_range(0, 2)) frame_words.push_back(noise_word());
    end
    if (frame_words.size() == 0) frame_words.push_back(noise_word());
  endtask

  task automatic send_word(input logic signed [WORD_W-1:0] w, input logic lst);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, w};
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_words.size(); i++)
      send_word(frame_words[i], i == frame_words.size() - 1);
    buffers_sent++;
  endtask

  task automatic run_random(input int n);
    int target;
    target = words_sent + n;
    while (words_sent < target) begin
      build_frame();
      send_frame();
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // non-last words may still sit in the queue
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CHOSEN_NAME:  name_q    = val;
      REG_MARKER_CODE:  marker_q  = val;
      REG_POLYGON_CODE: polygon_q = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CODE_W-1:0] nm, input logic [CODE_W-1:0] mk,
                                input logic [CODE_W-1:0] pg);
    drain();
    write_reg(REG_CHOSEN_NAME, nm);
    write_reg(REG_MARKER_CODE, mk);
    write_reg(REG_POLYGON_CODE, pg);
    settings_used++;
  endtask

  initial begin
    logic [CODE_W-1:0] r;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset register values
    frame_words = '{0};
    send_frame();
    // negative alias of the marker, name mismatch re-tested as marker, extreme coords,
    // zero and negative counts, end of object, then ignored trailing words
    frame_words = '{-1792, 1792, 5, 1792, 0, 1795, 2, -1048576, 1048575,
                    1048575, -1048576, 1795, 0, 1795, -3, 1792, 1795, 9};
    send_frame();
    // saturating count, buffer ends inside the polygon
    frame_words = '{1792, 0, 1795, 40000, 3, 4, 5};
    send_frame();

    run_random(75);

    apply_settings(16'hFFFF, 16'h0000, 16'hFFFE);
    run_random(75);

    apply_settings(16'h0000, 16'hFFFF, 16'h0000);
    run_random(30);
    // long receiver hold-off while a burst of one-word buffers piles up
    rx_hold_req = 1'b1;
    repeat (24) begin
      frame_words = '{noise_word()};
      send_frame();
    end
    run_random(30);

    // name equal to the marker value
    r = CODE_W'($urandom);
    apply_settings(r, r, r ^ 16'd1);
    run_random(75);

    apply_settings(CODE_W'($urandom), CODE_W'($urandom), CODE_W'($urandom));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(35);
    tx_idle_pct = 29;
    rx_idle_pct = 29;
    run_random(35);

    drain();
    $display("Sent %0d words in %0d buffers under %0d register settings;",
             words_sent, buffers_sent, settings_used);
    $display("checked %0d rectangles, %0d mismatches, %0d still outstanding.",
             rects_checked, fail_count, pending);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
hw/rtl/ftbb_pkg.sv
hw/rtl/ftbb_front.sv
hw/rtl/ftbb_queue.sv
hw/rtl/ftbb_back.sv
hw/rtl/feedback_token_bounding_box_unit.sv
dv/feedback_token_bounding_box_checker.sv
dv/tb_feedback_token_bounding_box_unit.sv
